// ===== rtl/tmd_pkg.sv =====
// shared types and codes for the typed message deframer
package tmd_pkg;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_COUNT   = 3'd1,
    PH_PAD     = 3'd2,
    PH_ID      = 3'd3,
    PH_VALUE   = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  localparam logic [7:0] TYPE_RECORDS = 8'd0;
  localparam logic [7:0] TYPE_BUFFER  = 8'd1;

  localparam logic [2:0] COUNT_LAST_POS = 3'd3;
  localparam logic [2:0] PAD_LAST_POS   = 3'd2;
  localparam logic [2:0] WORD_LAST_POS  = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] msg_id;
    logic signed [63:0] rec_value;
    logic [7:0]         payload_byte;
    logic               last;
  } result_t;

endpackage

// ===== rtl/typed_message_deframer.sv =====
// typed message deframer: byte stream in, id/value records and buffer bytes out
//
// One received byte is taken per clock cycle while in_ready is high; the parser
// state (phase, byte position, item count and the two 64-bit field assemblers)
// updates in the cycle the byte is accepted, and any result is registered into a
// two-entry output buffer, into its second entry while the first is held.
// in_ready drops only while both output entries hold results that the
// downstream side has not taken, so with out_ready held high the block
// sustains one byte per cycle. A byte other than 0 or 1 where a type byte is
// expected is dropped and the block keeps waiting for a type byte.
module typed_message_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [63:0] out_msg_id,
  output logic signed [63:0] out_rec_value,
  output logic [7:0]         out_payload_byte,
  output logic               out_last
);
  import tmd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        msg_type_r, msg_type_nxt;
  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] items_left_r, items_left_nxt;
  logic [63:0] id_acc_r, id_acc_nxt;
  logic [63:0] value_acc_r, value_acc_nxt;

  result_t     res;
  logic        emit;

  result_t     out_r, out_nxt;
  logic        out_v_r, out_v_nxt;
  result_t     skid_r, skid_nxt;
  logic        skid_v_r, skid_v_nxt;

  logic        fire_in;
  logic        take;

  assign in_ready = !skid_v_r;
  assign fire_in  = in_valid && in_ready;
  assign take     = out_v_r && out_ready;

  // parser next state
  always_comb begin
    phase_nxt      = phase_r;
    msg_type_nxt   = msg_type_r;
    byte_pos_nxt   = byte_pos_r;
    items_left_nxt = items_left_r;
    id_acc_nxt     = id_acc_r;
    value_acc_nxt  = value_acc_r;
    emit           = 1'b0;
    res.kind         = KIND_RECORD;
    res.msg_id       = id_acc_r;
    res.rec_value    = '0;
    res.payload_byte = '0;
    res.last         = 1'b0;

    unique case (phase_r)
      PH_COUNT: begin
        items_left_nxt[{byte_pos_r[1:0], 3'b000} +: 8] =
          items_left_r[{byte_pos_r[1:0], 3'b000} +: 8] | in_rx_byte;
        if (byte_pos_r >= COUNT_LAST_POS) begin
          phase_nxt    = PH_PAD;
          byte_pos_nxt = '0;
        end else begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end
      end
      PH_PAD: begin
        if (byte_pos_r < PAD_LAST_POS) begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end else begin
          byte_pos_nxt = '0;
          if (items_left_r[31]) items_left_nxt = '0;
          id_acc_nxt    = '0;
          value_acc_nxt = '0;
          if (!msg_type_r && (items_left_nxt == 32'd0)) phase_nxt = PH_TYPE;
          else phase_nxt = PH_ID;
        end
      end
      PH_ID: begin
        id_acc_nxt[{byte_pos_r, 3'b000} +: 8] =
          id_acc_r[{byte_pos_r, 3'b000} +: 8] | in_rx_byte;
        if (byte_pos_r < WORD_LAST_POS) begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end else begin
          byte_pos_nxt = '0;
          if (!msg_type_r) begin
            value_acc_nxt = '0;
            phase_nxt     = PH_VALUE;
          end else if (items_left_r == 32'd0) begin
            phase_nxt  = PH_TYPE;
            emit       = 1'b1;
            res.kind   = KIND_EMPTY;
            res.msg_id = id_acc_nxt;
            res.last   = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_VALUE: begin
        value_acc_nxt[{byte_pos_r, 3'b000} +: 8] =
          value_acc_r[{byte_pos_r, 3'b000} +: 8] | in_rx_byte;
        if (byte_pos_r < WORD_LAST_POS) begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end else begin
          byte_pos_nxt   = '0;
          emit           = 1'b1;
          res.kind       = KIND_RECORD;
          res.rec_value  = value_acc_nxt;
          res.last       = (items_left_r == 32'd1);
          items_left_nxt = items_left_r - 32'd1;
          if (items_left_nxt == 32'd0) begin
            phase_nxt = PH_TYPE;
          end else begin
            id_acc_nxt = '0;
            phase_nxt  = PH_ID;
          end
        end
      end
      PH_PAYLOAD: begin
        emit             = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = in_rx_byte;
        res.last         = (items_left_r == 32'd1);
        items_left_nxt   = items_left_r - 32'd1;
        if (items_left_nxt == 32'd0) phase_nxt = PH_TYPE;
      end
      default: begin
        if ((in_rx_byte == TYPE_RECORDS) || (in_rx_byte == TYPE_BUFFER)) begin
          msg_type_nxt   = in_rx_byte[0];
          phase_nxt      = PH_COUNT;
          byte_pos_nxt   = '0;
          items_left_nxt = '0;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
    endcase
  end

  // two-entry output buffer
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (fire_in && emit) begin
      if (!out_v_r || take) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TYPE;
      msg_type_r   <= 1'b0;
      byte_pos_r   <= '0;
      items_left_r <= '0;
      id_acc_r     <= '0;
      value_acc_r  <= '0;
      out_v_r      <= 1'b0;
      skid_v_r     <= 1'b0;
    end else begin
      if (fire_in) begin
        phase_r      <= phase_nxt;
        msg_type_r   <= msg_type_nxt;
        byte_pos_r   <= byte_pos_nxt;
        items_left_r <= items_left_nxt;
        id_acc_r     <= id_acc_nxt;
        value_acc_r  <= value_acc_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_kind         = out_r.kind;
  assign out_msg_id       = out_r.msg_id;
  assign out_rec_value    = out_r.rec_value;
  assign out_payload_byte = out_r.payload_byte;
  assign out_last         = out_r.last;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the typed message deframer
module tb_top;
  import tmd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int RESET_CYCLES = 11;
  localparam int TARGET_BYTES = 600;
  localparam int MIN_RESULTS  = 48;
  localparam int PAUSE_EVERY  = 150;

  localparam logic [1:0] SINK_OPEN      = 2'd0;
  localparam logic [1:0] SINK_CHOPPY    = 2'd1;
  localparam logic [1:0] SINK_THROTTLED = 2'd2;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } rx_slot_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'd0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [1:0]         out_kind;
  logic signed [63:0] out_msg_id;
  logic signed [63:0] out_rec_value;
  logic [7:0]         out_payload_byte;
  logic               out_last;

  // parser state mirrored by the predictor
  phase_t      parse_ph  = PH_TYPE;
  logic        is_buffer = 1'b0;
  logic [2:0]  field_pos = 3'd0;
  logic [31:0] remaining = 32'd0;
  logic [63:0] id_word   = 64'd0;
  logic [63:0] val_word  = 64'd0;

  result_t  pending_results[$];
  result_t  next_result;
  rx_slot_t rx_stream[$];
  bit       pause_next      = 1'b0;
  int       bytes_planned   = 0;
  int       results_planned = 0;
  int       total_bytes     = 0;
  int       bytes_sent      = 0;
  int       errors          = 0;
  int       burst_left      = 0;
  int       gap_left        = 0;
  int       mode_left       = 0;
  logic [1:0] sink_mode     = SINK_OPEN;
  int       idle_cycles     = 0;

  typed_message_deframer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_msg_id      (out_msg_id),
    .out_rec_value   (out_rec_value),
    .out_payload_byte(out_payload_byte),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void expect_result(input logic [1:0] kind, input logic [63:0] id,
                                        input logic [63:0] val, input logic [7:0] pb,
                                        input logic last);
    result_t r;
    r.kind         = kind;
    r.msg_id       = id;
    r.rec_value    = val;
    r.payload_byte = pb;
    r.last         = last;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    case (parse_ph)
      PH_COUNT: begin
        remaining = remaining | ({24'd0, b} << (8 * field_pos[1:0]));
        if (field_pos >= COUNT_LAST_POS) begin
          parse_ph  = PH_PAD;
          field_pos = 3'd0;
        end else begin
          field_pos = field_pos + 3'd1;
        end
      end
      PH_PAD: begin
        if (field_pos < PAD_LAST_POS) begin
          field_pos = field_pos + 3'd1;
        end else begin
          field_pos = 3'd0;
          if (remaining[31]) remaining = 32'd0;
          id_word  = 64'd0;
          val_word = 64'd0;
          if (!is_buffer && remaining == 32'd0) parse_ph = PH_TYPE;
          else parse_ph = PH_ID;
        end
      end
      PH_ID: begin
        id_word = id_word | ({56'd0, b} << (8 * field_pos));
        if (field_pos < WORD_LAST_POS) begin
          field_pos = field_pos + 3'd1;
        end else begin
          field_pos = 3'd0;
          if (!is_buffer) begin
            val_word = 64'd0;
            parse_ph = PH_VALUE;
          end else if (remaining == 32'd0) begin
            parse_ph = PH_TYPE;
            expect_result(KIND_EMPTY, id_word, 64'd0, 8'd0, 1'b1);
          end else begin
            parse_ph = PH_PAYLOAD;
          end
        end
      end
      PH_VALUE: begin
        val_word = val_word | ({56'd0, b} << (8 * field_pos));
        if (field_pos < WORD_LAST_POS) begin
          field_pos = field_pos + 3'd1;
        end else begin
          field_pos = 3'd0;
          expect_result(KIND_RECORD, id_word, val_word, 8'd0, remaining == 32'd1);
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            parse_ph = PH_TYPE;
          end else begin
            id_word  = 64'd0;
            parse_ph = PH_ID;
          end
        end
      end
      PH_PAYLOAD: begin
        expect_result(KIND_PAYLOAD, id_word, 64'd0, b, remaining == 32'd1);
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) parse_ph = PH_TYPE;
      end
      default: begin
        if (b == TYPE_RECORDS || b == TYPE_BUFFER) begin
          is_buffer = (b == TYPE_BUFFER);
          parse_ph  = PH_COUNT;
          field_pos = 3'd0;
          remaining = 32'd0;
        end else begin
          parse_ph = PH_TYPE;
        end
      end
    endcase
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    rx_slot_t s;
    s.data        = b;
    s.drain_first = pause_next;
    pause_next    = 1'b0;
    rx_stream.push_back(s);
    bytes_planned++;
  endfunction

  function automatic void put_word(input logic [63:0] w, input int nbytes);
    for (int k = 0; k < nbytes; k++) put_byte(w[8*k +: 8]);
  endfunction

  // unknown type bytes are skipped by the block
  function automatic void put_noise(input logic [7:0] b);
    put_byte(b);
    bytes_planned--;
  endfunction

  function automatic void put_records(input logic [31:0] cnt, input logic [63:0] id0,
                                      input logic [63:0] val0);
    int pairs;
    pairs = cnt[31] ? 0 : int'(cnt);
    put_byte(TYPE_RECORDS);
    put_word({32'd0, cnt}, 4);
    put_word(rand64(), 3);
    for (int k = 0; k < pairs; k++) begin
      put_word(k == 0 ? id0 : rand64(), 8);
      put_word(k == 0 ? val0 : rand64(), 8);
    end
    results_planned += pairs;
  endfunction

  function automatic void put_buffer(input logic [31:0] len, input logic [63:0] id,
                                     input logic [7:0] pb0);
    int nbytes;
    nbytes = len[31] ? 0 : int'(len);
    put_byte(TYPE_BUFFER);
    put_word({32'd0, len}, 4);
    put_word(rand64(), 3);
    put_word(id, 8);
    for (int k = 0; k < nbytes; k++) put_byte(k == 0 ? pb0 : 8'($urandom));
    results_planned += (nbytes == 0) ? 1 : nbytes;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch expected %h actual %h", $time, name, want_v, got_v);
    end
  endfunction

  initial begin
    int sel;
    int last_pause;
    last_pause = 0;

    // directed messages
    put_noise(8'h02);
    put_noise(8'hFF);
    put_records(32'd1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    put_records(32'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    put_records(32'd0, 64'd0, 64'd0);
    put_records(32'h8000_0000, 64'd0, 64'd0);
    put_records(32'hFFFF_FFFF, 64'd0, 64'd0);
    put_noise(8'h80);
    put_buffer(32'd0, 64'd0, 8'd0);
    put_buffer(32'h8000_0003, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
    put_buffer(32'd3, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    put_buffer(32'd1, 64'h8000_0000_0000_0000, 8'h00);
    put_records(32'd1, rand64(), rand64());

    // random messages
    while (bytes_planned < TARGET_BYTES || results_planned < MIN_RESULTS) begin
      if (bytes_planned - last_pause >= PAUSE_EVERY || last_pause == 0) begin
        pause_next = 1'b1;
        last_pause = bytes_planned;
      end
      sel = $urandom_range(0, 19);
      if (sel < 7) begin
        put_records($urandom_range(1, 3), rand64(), rand64());
      end else if (sel < 14) begin
        put_buffer($urandom_range(1, 10), rand64(), 8'($urandom));
      end else if (sel == 14) begin
        put_records($urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)}, 64'd0, 64'd0);
      end else if (sel == 15) begin
        put_buffer($urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)}, rand64(), 8'd0);
      end else begin
        repeat ($urandom_range(1, 3)) put_noise(8'($urandom_range(2, 255)));
      end
    end
    total_bytes = rx_stream.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent != total_bytes || pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_rx_byte(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() > 0 &&
                     !(rx_stream[0].drain_first && pending_results.size() > 0)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_stream[0].data;
          void'(rx_stream.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: switches between open, choppy and throttled stretches
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode = 2'($urandom_range(0, 2));
      mode_left = $urandom_range(8, 60);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer expected none actual kind=%0d id=%h", $time,
                 out_kind, out_msg_id);
      end else begin
        next_result = pending_results.pop_front();
        check_field("kind", 64'(next_result.kind), 64'(out_kind));
        check_field("msg_id", next_result.msg_id, out_msg_id);
        check_field("rec_value", next_result.rec_value, out_rec_value);
        check_field("payload_byte", 64'(next_result.payload_byte), 64'(out_payload_byte));
        check_field("last", 64'(next_result.last), 64'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
